// ----- rtl/ipv4_host_rule_matcher_macros.svh -----
// Assertion helpers for the host rule matcher.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef IPV4_HOST_RULE_MATCHER_MACROS_SVH
`define IPV4_HOST_RULE_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IHRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define IHRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ihrm_pkg.sv -----
`timescale 1ns / 1ps

package ihrm_pkg;

	// Characters the parser reacts to
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_FIVE   = 8'h35;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	localparam int unsigned OCTET_MAX = 255;
	localparam int unsigned NUM_TRK   = 4;

	// Octet parse phase of one track
	typedef enum logic [2:0] {
		PH_EXPECT = 3'b001,
		PH_DIGITS = 3'b010,
		PH_AFTER  = 3'b100
	} phase_t;

	// One parse track: three closed octets, the open octet and its status
	typedef struct packed {
		logic [23:0] value;
		logic [8:0]  octet;
		logic [1:0]  count;
		phase_t      phase;
		logic        err;
	} trk_t;

	localparam trk_t TRK_RESET = '{
		value: 24'd0, octet: 9'd0, count: 2'd0, phase: PH_EXPECT, err: 1'b0
	};

	// Per-token flags
	typedef struct packed {
		logic started;
		logic letter;
		logic dash;
		logic star;
		logic upper;
	} tok_t;

	localparam tok_t TOK_RESET = '0;

	// One input word
	typedef struct packed {
		logic [7:0]  rule_char;
		logic [31:0] dest_addr;
		logic        last_char;
		logic        empty_rule;
	} item_t;

	// Advance one track by one character
	function automatic trk_t trk_feed(trk_t t, logic [7:0] c);
		trk_t        r;
		logic [12:0] v;
		r = t;
		v = 13'd0;
		if (!t.err) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (t.phase != PH_AFTER) begin
					v = 13'(t.octet) * 13'd10 + 13'(c - CH_ZERO);
					if (v > 13'(OCTET_MAX)) begin
						r.err   = 1'b1;
						r.octet = 9'd256;
					end else begin
						r.octet = v[8:0];
					end
					r.phase = PH_DIGITS;
				end
			end else if (c == CH_DOT) begin
				if (t.phase == PH_EXPECT || t.count == 2'd3) begin
					r.err = 1'b1;
				end else begin
					r.value = {t.value[15:0], t.octet[7:0]};
					r.count = t.count + 2'd1;
					r.octet = 9'd0;
					r.phase = PH_EXPECT;
				end
			end else if (t.phase == PH_EXPECT) begin
				r.err = 1'b1;
			end else begin
				r.phase = PH_AFTER;
			end
		end
		return r;
	endfunction

	// A track gives an address when four octets closed cleanly
	function automatic logic trk_ok(trk_t t);
		return !t.err && t.phase != PH_EXPECT && t.count == 2'd3;
	endfunction

	function automatic logic [31:0] trk_addr(trk_t t);
		return {t.value, t.octet[7:0]};
	endfunction

endpackage

// ----- rtl/ihrm_if.sv -----
`timescale 1ns / 1ps

// Rule character stream
interface ihrm_rule_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rule_char;
	logic [31:0] dest_addr;
	logic        last_char;
	logic        empty_rule;

	modport source (output valid, rule_char, dest_addr, last_char, empty_rule, input ready);
	modport sink   (input valid, rule_char, dest_addr, last_char, empty_rule, output ready);
endinterface

// Match verdict stream
interface ihrm_match_if;
	logic valid;
	logic ready;
	logic host_matched;

	modport source (output valid, host_matched, input ready);
	modport sink   (input valid, host_matched, output ready);
endinterface

// ----- rtl/ipv4_host_rule_matcher.sv -----
// A verdict word is registered: the word that ends the string passes the input register, then the result register.
// Throughput: one character word per cycle, one state update each; a string end waits while a verdict is untaken.
// The output register lets a new character enter while a verdict waits.
// Reset: arst_n clears all parse state and empties both registers at once.
`timescale 1ns / 1ps

`include "ipv4_host_rule_matcher_macros.svh"

module ipv4_host_rule_matcher (
	input  logic          clk,
	input  logic          arst_n,
	ihrm_rule_if.sink     chars,
	ihrm_match_if.source  verdict
);

	ihrm_pkg::item_t item_s1;
	ihrm_pkg::item_t item_in;
	logic            valid_s1;
	logic            emits;
	logic            adv;
	logic            hit;
	logic            out_valid_q;
	logic            matched_q;

	assign item_in = '{
		rule_char:  chars.rule_char,
		dest_addr:  chars.dest_addr,
		last_char:  chars.last_char,
		empty_rule: chars.empty_rule
	};

	// Advance the stage unless its verdict has no free slot
	assign emits       = item_s1.last_char | item_s1.empty_rule;
	assign adv         = valid_s1 && (!emits || !out_valid_q || verdict.ready);
	assign chars.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1 <= item_in;
		end
	end

	ihrm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.hit    (hit)
	);

	// Result register: drop on take, load on a string end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && emits) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emits) begin
			matched_q <= hit;
		end
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.host_matched = matched_q;

	// Checks
	`IHRM_ASSERT_NOW(a_no_overwrite, out_valid_q && !verdict.ready, !(adv && emits), "verdict overwritten before taken")
	`IHRM_ASSERT_NOW(a_char_no_stall, valid_s1 && !emits, adv, "character word stalled without a verdict")
	`IHRM_ASSERT_NEXT(a_empty_match, adv && item_s1.empty_rule, verdict.valid && verdict.host_matched, "empty rule did not match")

endmodule

// ----- rtl/ihrm_core.sv -----
`timescale 1ns / 1ps

module ihrm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  ihrm_pkg::item_t item,
	output logic           hit
);

	ihrm_pkg::trk_t trk_q [ihrm_pkg::NUM_TRK];
	ihrm_pkg::trk_t nt    [ihrm_pkg::NUM_TRK];
	ihrm_pkg::tok_t tok_q;
	ihrm_pkg::tok_t nf;
	logic           match_q;

	logic [7:0]     c;
	logic           sp;
	logic           letter;
	logic           semi;
	logic           end_now;
	logic           tok_hit;
	logic           range_ok;
	logic           exact_ok;
	logic           match_next;
	ihrm_pkg::trk_t lo_trk;
	ihrm_pkg::trk_t hi_trk;
	logic [31:0]    lo_addr;
	logic [31:0]    hi_addr;

	// Classify the character
	assign c      = item.rule_char;
	assign sp     = c == ihrm_pkg::CH_SPACE || (c >= ihrm_pkg::CH_TAB && c <= ihrm_pkg::CH_CR);
	assign letter = (c >= ihrm_pkg::CH_UP_A && c <= ihrm_pkg::CH_UP_Z) ||
	                (c >= ihrm_pkg::CH_LO_A && c <= ihrm_pkg::CH_LO_Z);
	assign semi   = c == ihrm_pkg::CH_SEMI;

	// Take one character into the token flags and tracks
	always_comb begin
		nt = trk_q;
		nf = tok_q;
		if (!semi && (tok_q.started || !sp)) begin
			nf.started = 1'b1;
			if (letter) begin
				nf.letter = 1'b1;
			end
			if (c == ihrm_pkg::CH_STAR) begin
				nf.star = 1'b1;
				nt[0] = ihrm_pkg::trk_feed(trk_q[0], ihrm_pkg::CH_ZERO);
				nt[1] = ihrm_pkg::trk_feed(ihrm_pkg::trk_feed(ihrm_pkg::trk_feed(
				        trk_q[1], ihrm_pkg::CH_TWO), ihrm_pkg::CH_FIVE), ihrm_pkg::CH_FIVE);
			end else begin
				nt[0] = ihrm_pkg::trk_feed(trk_q[0], c);
				nt[1] = ihrm_pkg::trk_feed(trk_q[1], c);
			end
			if (!tok_q.dash) begin
				if (c == ihrm_pkg::CH_DASH) begin
					nf.dash = 1'b1;
				end else begin
					nt[2] = ihrm_pkg::trk_feed(trk_q[2], c);
				end
			end else if (tok_q.upper || !sp) begin
				nf.upper = 1'b1;
				nt[3] = ihrm_pkg::trk_feed(trk_q[3], c);
			end
		end
	end

	// Resolve the token against the destination
	assign lo_trk   = nf.dash ? nt[2] : nt[0];
	assign hi_trk   = nf.dash ? nt[3] : nt[1];
	assign lo_addr  = ihrm_pkg::trk_addr(lo_trk);
	assign hi_addr  = ihrm_pkg::trk_addr(hi_trk);
	assign range_ok = ihrm_pkg::trk_ok(lo_trk) && ihrm_pkg::trk_ok(hi_trk) &&
	                  item.dest_addr >= lo_addr && item.dest_addr <= hi_addr;
	assign exact_ok = ihrm_pkg::trk_ok(nt[0]) && item.dest_addr == ihrm_pkg::trk_addr(nt[0]);
	assign tok_hit  = nf.started && !nf.letter && ((nf.dash || nf.star) ? range_ok : exact_ok);

	assign end_now    = semi || item.last_char;
	assign match_next = match_q | (end_now & tok_hit);
	assign hit        = item.empty_rule | match_next;

	// Update state: clear at string end, clear the token at a separator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			tok_q   <= ihrm_pkg::TOK_RESET;
			for (int i = 0; i < ihrm_pkg::NUM_TRK; i++) begin
				trk_q[i] <= ihrm_pkg::TRK_RESET;
			end
		end else if (step) begin
			if (item.empty_rule || item.last_char) begin
				match_q <= 1'b0;
				tok_q   <= ihrm_pkg::TOK_RESET;
				for (int i = 0; i < ihrm_pkg::NUM_TRK; i++) begin
					trk_q[i] <= ihrm_pkg::TRK_RESET;
				end
			end else if (semi) begin
				match_q <= match_next;
				tok_q   <= ihrm_pkg::TOK_RESET;
				for (int i = 0; i < ihrm_pkg::NUM_TRK; i++) begin
					trk_q[i] <= ihrm_pkg::TRK_RESET;
				end
			end else begin
				tok_q <= nf;
				trk_q <= nt;
			end
		end
	end

endmodule
